### hw/rtl/sbcpu_pkg.sv
// ----------------------------------------------------------------------------
// sbcpu_pkg
// shared types, codes and constants of the 16-bit instruction step core
// ----------------------------------------------------------------------------
package sbcpu_pkg;

  localparam int unsigned MemWords = 65536;
  localparam int unsigned MemAw    = $clog2(MemWords);
  localparam int unsigned RegCount = 8;
  localparam int unsigned InWidth  = 40;
  localparam int unsigned OutWidth = 40;

  localparam logic [15:0] PcReset  = 16'h8200;
  localparam logic [2:0]  NzpReset = 3'b010;

  // command codes
  localparam logic [2:0] CmdWrMem = 3'd0;
  localparam logic [2:0] CmdSetReg = 3'd1;
  localparam logic [2:0] CmdBreak = 3'd2;
  localparam logic [2:0] CmdStep  = 3'd3;
  localparam logic [2:0] CmdRdReg = 3'd4;

  localparam logic [3:0] RegPcSel = 4'd8;

  // status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIllegal = 2'd1;
  localparam logic [1:0] StBreak   = 2'd2;
  localparam logic [1:0] StUndef   = 2'd3;

  // opcodes
  localparam logic [3:0] OpBr    = 4'h0;
  localparam logic [3:0] OpArith = 4'h1;
  localparam logic [3:0] OpCmp   = 4'h2;
  localparam logic [3:0] OpJsr   = 4'h4;
  localparam logic [3:0] OpLogic = 4'h5;
  localparam logic [3:0] OpLdr   = 4'h6;
  localparam logic [3:0] OpStr   = 4'h7;
  localparam logic [3:0] OpRti   = 4'h8;
  localparam logic [3:0] OpConst = 4'h9;
  localparam logic [3:0] OpShift = 4'hA;
  localparam logic [3:0] OpJmp   = 4'hC;
  localparam logic [3:0] OpHicon = 4'hD;
  localparam logic [3:0] OpTrap  = 4'hF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_RDB,
    S_RDX,
    S_EXEC,
    S_DIV,
    S_LOAD,
    S_COMMIT,
    S_FINISH
  } state_t;

  // controller to datapath, one phase strobe at a time
  typedef struct packed {
    logic clr;
    logic take;
    logic dec;
    logic rdb;
    logic rdx;
    logic exec;
    logic div_wait;
    logic load;
    logic commit;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic step_go;
    logic op_div;
    logic op_ld;
    logic op_undef;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/sbcpu_ram.sv
// ----------------------------------------------------------------------------
// sbcpu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module sbcpu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/sbcpu_div.sv
// ----------------------------------------------------------------------------
// sbcpu_div
// 16-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sbcpu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);

  logic [15:0] rem;
  logic [15:0] quo;
  logic [15:0] dvs;
  logic [4:0]  cnt;
  logic [16:0] trial;

  assign trial     = {rem, quo[15]} - {1'b0, dvs};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 5'd16;
      end else if (cnt != 5'd0) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != 5'd0) begin
      if (!trial[16]) begin
        rem <= trial[15:0];
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= {rem[14:0], quo[15]};
        quo <= {quo[14:0], 1'b0};
      end
    end
  end

endmodule

### hw/rtl/sbcpu_dp.sv
// ----------------------------------------------------------------------------
// sbcpu_dp
// datapath: architectural state, memories, alu, divider and result register
// ----------------------------------------------------------------------------
module sbcpu_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sbcpu_pkg::dp_cmd_t                   cmd,
  output sbcpu_pkg::dp_stat_t                  st,
  input  logic [sbcpu_pkg::InWidth-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [sbcpu_pkg::OutWidth-1:0]       m_tdata
);

  // input fields
  logic [2:0]  in_command;
  logic [15:0] in_address;
  logic [3:0]  in_reg_index;
  logic [15:0] in_value;
  logic        in_mark;

  assign in_command   = s_tdata[2:0];
  assign in_address   = s_tdata[18:3];
  assign in_reg_index = s_tdata[22:19];
  assign in_value     = s_tdata[38:23];
  assign in_mark      = s_tdata[39];

  // architectural state
  logic [15:0] pc;
  logic [2:0]  nzp;
  logic        priv;

  // clear sweep
  logic [sbcpu_pkg::MemAw-1:0] clr_cnt;

  // per-step working registers
  logic [15:0] ir;
  logic [15:0] a;
  logic [15:0] b;
  logic [15:0] res;
  logic [15:0] rv;
  logic [15:0] pc_pend;
  logic        priv_pend;
  logic [2:0]  wd;
  logic        wreg;
  logic        cmp;
  logic [2:0]  cmp_nzp;
  logic [1:0]  stat_pend;
  logic        rv_from_rf;
  logic        chk_brk;

  // output register
  logic                              out_valid;
  logic [sbcpu_pkg::OutWidth-1:0]    out_data;

  // ram ports
  logic                              mem_we, mem_re;
  logic [sbcpu_pkg::MemAw-1:0]       mem_waddr, mem_raddr;
  logic [15:0]                       mem_wdata, mem_q;
  logic                              brk_we, brk_re;
  logic [sbcpu_pkg::MemAw-1:0]       brk_waddr;
  logic [0:0]                        brk_wdata, brk_q;
  logic                              rf_we, rf_re;
  logic [2:0]                        rf_waddr, rf_raddr;
  logic [15:0]                       rf_wdata, rf_q;

  // divider
  logic        div_done;
  logic [15:0] div_quo, div_rem;

  // decode
  logic [3:0]  op;
  logic [15:0] x;
  logic [15:0] pc_inc;
  logic [15:0] sx5, sx6, sx7, sx9, sx11;
  logic [15:0] ls_addr;
  logic [31:0] prod;
  logic [16:0] diff;
  logic        pc_ok;
  logic        ri_reg;

  // execute results
  logic [15:0] e_res;
  logic [15:0] e_pc;
  logic        e_priv;
  logic        e_wreg;
  logic [2:0]  e_wd;
  logic        e_cmp;

  function automatic logic [2:0] nzp_of(input logic [16:0] v);
    logic [2:0] f;
    if (v[16]) begin
      f = 3'b100;
    end else if (v == 17'd0) begin
      f = 3'b010;
    end else begin
      f = 3'b001;
    end
    return f;
  endfunction

  assign op     = ir[15:12];
  assign x      = rf_q;
  assign pc_inc = pc + 16'd1;
  assign sx5    = {{11{ir[4]}}, ir[4:0]};
  assign sx6    = {{10{ir[5]}}, ir[5:0]};
  assign sx7    = {{9{ir[6]}}, ir[6:0]};
  assign sx9    = {{7{ir[8]}}, ir[8:0]};
  assign sx11   = {{5{ir[10]}}, ir[10:0]};
  assign ls_addr = a + sx6;
  assign prod   = a * b;
  assign ri_reg = (in_reg_index[3] == 1'b0);

  // code space: user region below 0x2000, os region 0x8000-0x9fff when privileged
  assign pc_ok = (pc[15:13] == 3'b000) || ((pc[15:13] == 3'b100) && priv);

  always_comb begin
    unique case (ir[8:7])
      2'd0:    diff = {x[15], x} - {b[15], b};
      2'd1:    diff = {1'b0, x} - {1'b0, b};
      2'd2:    diff = {x[15], x} - {sx7[15], sx7};
      default: diff = {1'b0, x} - {10'd0, ir[6:0]};
    endcase
  end

  // execute stage result selection
  always_comb begin
    e_res  = '0;
    e_pc   = pc_inc;
    e_priv = priv;
    e_wreg = 1'b0;
    e_wd   = ir[11:9];
    e_cmp  = 1'b0;
    unique case (op)
      sbcpu_pkg::OpBr: begin
        if ((ir[11:9] & nzp) != 3'b000) begin
          e_pc = pc_inc + sx9;
        end
      end
      sbcpu_pkg::OpArith: begin
        e_wreg = 1'b1;
        if (ir[5]) begin
          e_res = a + sx5;
        end else begin
          unique case (ir[4:3])
            2'd0:    e_res = a + b;
            2'd1:    e_res = prod[15:0];
            2'd2:    e_res = a - b;
            default: e_res = '0;
          endcase
        end
      end
      sbcpu_pkg::OpLogic: begin
        e_wreg = 1'b1;
        if (ir[5]) begin
          e_res = a & sx5;
        end else begin
          unique case (ir[4:3])
            2'd0:    e_res = a & b;
            2'd1:    e_res = ~a;
            2'd2:    e_res = a | b;
            default: e_res = a ^ b;
          endcase
        end
      end
      sbcpu_pkg::OpCmp: begin
        e_cmp = 1'b1;
      end
      sbcpu_pkg::OpJsr: begin
        e_wreg = 1'b1;
        e_wd   = 3'd7;
        e_res  = pc_inc;
        // sign of the offset lands on bit 15 together with the pc page bit
        e_pc   = ir[11] ? {pc[15] | ir[10], ir[10:0], 4'b0000} : a;
      end
      sbcpu_pkg::OpLdr: begin
        e_wreg = 1'b1;
      end
      sbcpu_pkg::OpStr: begin
        e_res = x;
      end
      sbcpu_pkg::OpRti: begin
        e_pc   = x;
        e_priv = 1'b0;
      end
      sbcpu_pkg::OpConst: begin
        e_wreg = 1'b1;
        e_res  = sx9;
      end
      sbcpu_pkg::OpShift: begin
        e_wreg = 1'b1;
        unique case (ir[5:4])
          2'd0:    e_res = a << ir[3:0];
          2'd1:    e_res = $unsigned($signed(a) >>> ir[3:0]);
          2'd2:    e_res = a >> ir[3:0];
          default: e_res = '0;
        endcase
      end
      sbcpu_pkg::OpJmp: begin
        e_pc = ir[11] ? pc_inc + sx11 : a;
      end
      sbcpu_pkg::OpHicon: begin
        e_wreg = 1'b1;
        e_res  = {ir[7:0], x[7:0]};
      end
      sbcpu_pkg::OpTrap: begin
        e_wreg = 1'b1;
        e_wd   = 3'd7;
        e_res  = pc_inc;
        e_pc   = {8'h80, ir[7:0]};
        e_priv = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status to controller
  assign st.clr_last = (clr_cnt == '1);
  assign st.step_go  = (in_command == sbcpu_pkg::CmdStep) && pc_ok;
  assign st.op_div   = ((op == sbcpu_pkg::OpArith) && !ir[5] && (ir[4:3] == 2'd3))
                       || ((op == sbcpu_pkg::OpShift) && (ir[5:4] == 2'd3));
  assign st.op_ld    = (op == sbcpu_pkg::OpLdr);
  assign st.op_undef = (op == 4'h3) || (op == 4'hB) || (op == 4'hE);
  assign st.div_done = div_done;
  assign st.out_free = !out_valid || m_tready;

  // word memory ports
  always_comb begin
    mem_we    = cmd.clr || (cmd.take && (in_command == sbcpu_pkg::CmdWrMem))
                || (cmd.exec && (op == sbcpu_pkg::OpStr));
    mem_waddr = cmd.clr ? clr_cnt : (cmd.take ? in_address : ls_addr);
    mem_wdata = cmd.clr ? 16'd0 : (cmd.take ? in_value : x);
    mem_re    = (cmd.take && st.step_go) || (cmd.exec && (op == sbcpu_pkg::OpLdr));
    mem_raddr = cmd.take ? pc : ls_addr;
  end

  // breakpoint marks
  always_comb begin
    brk_we    = cmd.clr || (cmd.take && (in_command == sbcpu_pkg::CmdBreak));
    brk_waddr = cmd.clr ? clr_cnt : in_address;
    brk_wdata = cmd.clr ? 1'b0 : in_mark;
    brk_re    = cmd.commit;
  end

  // register file, one read per cycle
  always_comb begin
    rf_we    = cmd.clr || (cmd.take && (in_command == sbcpu_pkg::CmdSetReg) && ri_reg)
               || (cmd.commit && wreg);
    rf_waddr = cmd.clr ? clr_cnt[2:0] : (cmd.take ? in_reg_index[2:0] : wd);
    rf_wdata = cmd.clr ? 16'd0 : (cmd.take ? in_value : res);
    rf_re    = (cmd.take && (in_command == sbcpu_pkg::CmdRdReg) && ri_reg)
               || cmd.dec || cmd.rdb || cmd.rdx;
    priority if (cmd.take) begin
      rf_raddr = in_reg_index[2:0];
    end else if (cmd.dec) begin
      rf_raddr = mem_q[8:6];
    end else if (cmd.rdb) begin
      rf_raddr = ir[2:0];
    end else if (op == sbcpu_pkg::OpRti) begin
      rf_raddr = 3'd7;
    end else begin
      rf_raddr = ir[11:9];
    end
  end

  sbcpu_ram #(.WIDTH(16), .DEPTH(sbcpu_pkg::MemWords)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  sbcpu_ram #(.WIDTH(1), .DEPTH(sbcpu_pkg::MemWords)) u_brk (
    .clk   (clk),
    .we    (brk_we),
    .waddr (brk_waddr),
    .wdata (brk_wdata),
    .re    (brk_re),
    .raddr (pc_pend),
    .rdata (brk_q)
  );

  sbcpu_ram #(.WIDTH(16), .DEPTH(sbcpu_pkg::RegCount)) u_rf (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (rf_re),
    .raddr (rf_raddr),
    .rdata (rf_q)
  );

  sbcpu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.exec && st.op_div),
    .dividend  (a),
    .divisor   (b),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // architectural state and clear counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= sbcpu_pkg::PcReset;
      nzp     <= sbcpu_pkg::NzpReset;
      priv    <= 1'b1;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.take && (in_command == sbcpu_pkg::CmdSetReg)
          && (in_reg_index == sbcpu_pkg::RegPcSel)) begin
        pc <= in_value;
      end
      if (cmd.commit) begin
        pc   <= pc_pend;
        priv <= priv_pend;
        if (wreg) begin
          nzp <= nzp_of({res[15], res});
        end else if (cmd.commit && cmp) begin
          nzp <= cmp_nzp;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      stat_pend  <= (in_command == sbcpu_pkg::CmdStep && !pc_ok) ?
                    sbcpu_pkg::StIllegal : sbcpu_pkg::StOk;
      rv         <= (in_command == sbcpu_pkg::CmdRdReg && in_reg_index == sbcpu_pkg::RegPcSel)
                    ? pc : 16'd0;
      rv_from_rf <= (in_command == sbcpu_pkg::CmdRdReg) && ri_reg;
      chk_brk    <= 1'b0;
    end
    if (cmd.dec) begin
      ir <= mem_q;
    end
    if (cmd.rdb) begin
      a <= rf_q;
    end
    if (cmd.rdx) begin
      b <= rf_q;
    end
    if (cmd.exec) begin
      res       <= e_res;
      pc_pend   <= e_pc;
      priv_pend <= e_priv;
      wreg      <= e_wreg;
      wd        <= e_wd;
      cmp       <= e_cmp;
      cmp_nzp   <= nzp_of(diff);
      if (st.op_undef) begin
        stat_pend <= sbcpu_pkg::StUndef;
      end
    end
    if (cmd.div_wait && div_done) begin
      res <= (b == 16'd0) ? 16'd0 : ((op == sbcpu_pkg::OpShift) ? div_rem : div_quo);
    end
    if (cmd.load) begin
      res <= mem_q;
    end
    if (cmd.commit) begin
      rv      <= res;
      chk_brk <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && st.out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && st.out_free) begin
      out_data <= {2'b00, (rv_from_rf ? rf_q : rv), priv, nzp, pc,
                   ((chk_brk && brk_q[0]) ? sbcpu_pkg::StBreak : stat_pend)};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### hw/rtl/sbcpu_ctrl.sv
// ----------------------------------------------------------------------------
// sbcpu_ctrl
// controller: sequences the clear sweep, command intake and instruction phases
// ----------------------------------------------------------------------------
module sbcpu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  sbcpu_pkg::dp_stat_t  st,
  output sbcpu_pkg::dp_cmd_t   cmd
);

  sbcpu_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbcpu_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      sbcpu_pkg::S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_next = sbcpu_pkg::S_IDLE;
        end
      end
      sbcpu_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = st.step_go ? sbcpu_pkg::S_DEC : sbcpu_pkg::S_FINISH;
        end
      end
      sbcpu_pkg::S_DEC: begin
        cmd.dec    = 1'b1;
        state_next = sbcpu_pkg::S_RDB;
      end
      sbcpu_pkg::S_RDB: begin
        cmd.rdb    = 1'b1;
        state_next = sbcpu_pkg::S_RDX;
      end
      sbcpu_pkg::S_RDX: begin
        cmd.rdx    = 1'b1;
        state_next = sbcpu_pkg::S_EXEC;
      end
      sbcpu_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (st.op_undef) begin
          state_next = sbcpu_pkg::S_FINISH;
        end else if (st.op_div) begin
          state_next = sbcpu_pkg::S_DIV;
        end else if (st.op_ld) begin
          state_next = sbcpu_pkg::S_LOAD;
        end else begin
          state_next = sbcpu_pkg::S_COMMIT;
        end
      end
      sbcpu_pkg::S_DIV: begin
        cmd.div_wait = 1'b1;
        if (st.div_done) begin
          state_next = sbcpu_pkg::S_COMMIT;
        end
      end
      sbcpu_pkg::S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = sbcpu_pkg::S_COMMIT;
      end
      sbcpu_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = sbcpu_pkg::S_FINISH;
      end
      sbcpu_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        if (st.out_free) begin
          state_next = sbcpu_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sbcpu_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/sixteen_bit_cpu_instruction_step_core.sv
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_instruction_step_core
// 16-bit processor with command port, one result transaction per command
// ----------------------------------------------------------------------------
// after reset the core sweeps its word memory, breakpoint marks and register
// file to zero, one word per cycle, with s_tready low; then it takes one
// command transaction at a time. memory write, register set, breakpoint and
// read commands go straight from acceptance to the result phase. a step runs
// fetch, three register file reads through its single read port, execute,
// commit with breakpoint lookup and result; loads add a memory read phase,
// and div and mod wait on a bit-serial 16-step divider before commit.
// a finished result sits in an output register, so the next command can be
// accepted while it waits for m_tready.
module sixteen_bit_cpu_instruction_step_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // command, address, reg_index, value, mark (from bit 0 up)
  input  logic [sbcpu_pkg::InWidth-1:0]      s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status, program_counter, flags_nzp, privileged, reg_value, 2 zero bits
  output logic [sbcpu_pkg::OutWidth-1:0]     m_tdata
);

  // command and status links between controller and datapath
  sbcpu_pkg::dp_cmd_t  cmd;
  sbcpu_pkg::dp_stat_t st;

  sbcpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  sbcpu_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // at most one phase strobe per cycle
  a_one_phase: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath phase active");

  // no command taken during the clear sweep
  a_clear_block: assert property (@(posedge clk) disable iff (rst) cmd.clr |-> !s_tready)
    else $error("input ready during clear sweep");

  // one command in flight: an accepted transaction drops ready
  a_single: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second command taken while one is in flight");

  // finishing with room in the output register always presents a result
  a_result: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && st.out_free) |=> m_tvalid)
    else $error("finished command produced no result");

endmodule

### tb/sbcpu_step_checker.sv
// ----------------------------------------------------------------------------
// sbcpu_step_checker
// watches the command and result channels, predicts each result, compares
// ----------------------------------------------------------------------------
module sbcpu_step_checker
  import sbcpu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [InWidth-1:0]  s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [OutWidth-1:0] m_tdata,
  output int                  errors,
  output int                  pending,
  output int                  results_seen
);

  // highest field first, so status lands in the lowest bits
  typedef struct packed {
    logic [15:0] rv;
    logic        priv;
    logic [2:0]  nzp;
    logic [15:0] pc;
    logic [1:0]  status;
  } step_result_t;

  logic [15:0] gpr [8];
  logic [15:0] pc_q;
  logic [2:0]  nzp_q;
  logic        priv_q;
  logic [15:0] mem [MemWords];
  logic        bp [MemWords];
  step_result_t expected_q[$];

  assign pending = expected_q.size();

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic logic [2:0] nzp_of(input int signed v);
    return v < 0 ? 3'b100 : (v == 0 ? 3'b010 : 3'b001);
  endfunction

  function automatic logic [15:0] sext(input logic [15:0] v, input int bits);
    logic [15:0] r;
    r = v & ((16'h1 << bits) - 1);
    if (v[bits-1]) r = r | ~((16'h1 << bits) - 1);
    return r;
  endfunction

  // one instruction; returns status, sets write-back value
  function automatic logic [1:0] exec_insn(output logic [15:0] wr);
    logic [15:0] ir, a, b, nxt, res, adr, x;
    logic [3:0]  op;
    logic [2:0]  d, s, t;
    logic [1:0]  sub;
    int signed   diff;
    ir  = mem[pc_q];
    op  = ir[15:12];
    d   = ir[11:9];
    s   = ir[8:6];
    t   = ir[2:0];
    a   = gpr[s];
    b   = gpr[t];
    nxt = pc_q + 16'd1;
    wr  = '0;
    res = '0;
    case (op)
      OpBr: begin
        pc_q = (d & nzp_q) != 0 ? nxt + sext(ir, 9) : nxt;
        return StOk;
      end
      OpArith, OpLogic: begin
        sub = ir[4:3];
        if (ir[5]) res = (op == OpArith) ? a + sext(ir, 5) : a & sext(ir, 5);
        else if (op == OpArith)
          case (sub)
            2'd0: res = a + b;
            2'd1: res = a * b;
            2'd2: res = a - b;
            default: res = b != 0 ? a / b : 16'd0;
          endcase
        else
          case (sub)
            2'd0: res = a & b;
            2'd1: res = ~a;
            2'd2: res = a | b;
            default: res = a ^ b;
          endcase
      end
      OpCmp: begin
        x = gpr[d];
        case (ir[8:7])
          2'd0: diff = $signed(x) - $signed(b);
          2'd1: diff = int'(x) - int'(b);
          2'd2: diff = $signed(x) - $signed(sext(ir, 7));
          default: diff = int'(x) - int'(ir[6:0]);
        endcase
        nzp_q = nzp_of(diff);
        pc_q  = nxt;
        return StOk;
      end
      OpJsr: begin
        gpr[7] = nxt;
        nzp_q  = nzp_of($signed(nxt));
        pc_q   = ir[11] ? {pc_q[15] | ir[10], ir[10:0], 4'b0} : a;
        wr     = nxt;
        return StOk;
      end
      OpLdr: begin
        adr = a + sext(ir, 6);
        res = mem[adr];
      end
      OpStr: begin
        adr = a + sext(ir, 6);
        mem[adr] = gpr[d];
        wr   = gpr[d];
        pc_q = nxt;
        return StOk;
      end
      OpRti: begin
        pc_q   = gpr[7];
        priv_q = 1'b0;
        return StOk;
      end
      OpConst: res = sext(ir, 9);
      OpShift:
        case (ir[5:4])
          2'd0: res = a << ir[3:0];
          2'd1: res = $signed(a) >>> ir[3:0];
          2'd2: res = a >> ir[3:0];
          default: res = b != 0 ? a % b : 16'd0;
        endcase
      OpJmp: begin
        pc_q = ir[11] ? nxt + sext(ir, 11) : a;
        return StOk;
      end
      OpHicon: res = {ir[7:0], gpr[d][7:0]};
      OpTrap: begin
        gpr[7] = nxt;
        nzp_q  = nzp_of($signed(nxt));
        pc_q   = {8'h80, ir[7:0]};
        priv_q = 1'b1;
        wr     = nxt;
        return StOk;
      end
      default: return StUndef;
    endcase
    gpr[d] = res;
    nzp_q  = nzp_of($signed(res));
    wr     = res;
    pc_q   = nxt;
    return StOk;
  endfunction

  function automatic step_result_t predict_command(input logic [InWidth-1:0] c);
    step_result_t r;
    logic [2:0]  cmd;
    logic [15:0] adr, val;
    logic [3:0]  ri;
    cmd = c[2:0];
    adr = c[18:3];
    ri  = c[22:19];
    val = c[38:23];
    r.status = StOk;
    r.rv = '0;
    case (cmd)
      CmdWrMem: mem[adr] = val;
      CmdSetReg:
        if (ri < 8) gpr[ri[2:0]] = val;
        else if (ri == RegPcSel) pc_q = val;
      CmdBreak: bp[adr] = c[39];
      CmdStep:
        if ((pc_q >= 16'h2000 && pc_q < 16'h8000) || pc_q >= 16'hA000 ||
            (pc_q >= 16'h8000 && !priv_q))
          r.status = StIllegal;
        else begin
          r.status = exec_insn(r.rv);
          if (r.status == StOk && bp[pc_q]) r.status = StBreak;
        end
      CmdRdReg:
        if (ri < 8) r.rv = gpr[ri[2:0]];
        else if (ri == RegPcSel) r.rv = pc_q;
      default: ;
    endcase
    r.pc = pc_q;
    r.nzp = nzp_q;
    r.priv = priv_q;
    return r;
  endfunction

  step_result_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      foreach (gpr[i]) gpr[i] = '0;
      foreach (mem[i]) begin
        mem[i] = '0;
        bp[i]  = 1'b0;
      end
      pc_q = PcReset;
      nzp_q = NzpReset;
      priv_q = 1'b1;
      expected_q.delete();
      errors = 0;
      results_seen = 0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(predict_command(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[37:0];
        if (expected_q.size() == 0) begin
          $display("unexpected result transaction %h", m_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.pc != want.pc) report("program_counter", got.pc, want.pc);
          if (got.nzp != want.nzp) report("flags_nzp", got.nzp, want.nzp);
          if (got.priv != want.priv) report("privileged", got.priv, want.priv);
          if (got.rv != want.rv) report("reg_value", got.rv, want.rv);
        end
        results_seen++;
      end
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// command stimulus for the instruction step core with result checking
// ----------------------------------------------------------------------------
// directed commands first, then random programs: each round loads a few
// instruction words near the pc, sets registers and steps through them, with
// some noise commands mixed in. sender bursts and receiver stalls are random.
module tb;
  import sbcpu_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InWidth-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutWidth-1:0] m_tdata;
  int errors, pending, results_seen;
  int idle_cycles = 0;
  int sent = 0;
  int stall_mode = 0;

  localparam int WatchdogLimit = 200000; // covers the post-reset memory sweep

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sixteen_bit_cpu_instruction_step_core dut (.*);

  sbcpu_step_checker chk (.*);

  // receiver stall pattern: phases of always ready, random, mostly stalled
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= $urandom_range(0, 1);
      default: m_tready <= $urandom_range(0, 7) == 0;
    endcase
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("** sixteen_bit_cpu_instruction_step_core: FAILED **");
      $finish;
    end
  end

  int burst_left = 0;

  // send one command transaction; gaps only between bursts
  task automatic send_command(input logic [2:0] cmd, input logic [15:0] adr,
                              input logic [3:0] ri, input logic [15:0] val,
                              input logic mk);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {mk, val, ri, adr, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    sent++;
    if (burst_left == 0) s_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_insn();
    logic [15:0] w;
    w = $urandom_range(0, 65535);
    // rarely an undefined opcode
    if ($urandom_range(0, 15) != 0)
      while (w[15:12] == 4'h3 || w[15:12] == 4'hB || w[15:12] == 4'hE)
        w[15:12] = $urandom_range(0, 15);
    return w;
  endfunction

  logic [15:0] base;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_command(CmdRdReg, 16'h0, RegPcSel, 16'h0, 1'b0);
    send_command(CmdSetReg, 16'h0, 4'd1, 16'hFFFF, 1'b0);
    send_command(CmdSetReg, 16'h0, 4'd2, 16'h0000, 1'b0);
    send_command(CmdWrMem, 16'h8200, 4'd0, {OpArith, 3'd3, 3'd1, 3'b011, 3'd2}, 1'b0);
    send_command(CmdBreak, 16'h8201, 4'd0, 16'h0, 1'b1);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // divide by zero, breakpoint
    send_command(CmdWrMem, 16'h8201, 4'd0, {4'hB, 12'hFFF}, 1'b0);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // undefined opcode
    send_command(CmdWrMem, 16'h8201, 4'd0, {OpShift, 3'd4, 3'd1, 6'b110010}, 1'b0);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // mod by zero
    send_command(CmdWrMem, 16'h8202, 4'd0, {OpLdr, 3'd5, 3'd1, 6'b000001}, 1'b0);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // load wraps to address 0
    send_command(CmdWrMem, 16'h8203, 4'd0, {OpRti, 12'h0}, 1'b0);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // drop privilege, pc from r7
    send_command(CmdSetReg, 16'h0, RegPcSel, 16'h8000, 1'b0);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // os region while unprivileged
    send_command(CmdSetReg, 16'h0, RegPcSel, 16'hFFFF, 1'b0);
    send_command(CmdStep, 16'h0, 4'd0, 16'h0, 1'b0);       // illegal high region
    send_command(CmdSetReg, 16'h0, 4'd15, 16'h1234, 1'b0); // index above eight
    send_command(CmdRdReg, 16'h0, 4'd15, 16'h0, 1'b0);
    send_command(3'd7, 16'hFFFF, 4'd15, 16'hFFFF, 1'b1);   // unknown command
    send_command(CmdBreak, 16'h8201, 4'd0, 16'h0, 1'b0);

    // wait until every expected result is in
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // random programs
    while (sent < 1900) begin
      base = $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(16'h0000, 16'h1FF0));
      if ($urandom_range(0, 1)) base = base | 16'h8000;
      send_command(CmdSetReg, 16'h0, RegPcSel, base, 1'b0);
      for (int i = 0; i < 4; i++)
        send_command(CmdSetReg, 16'h0, 4'($urandom_range(0, 7)),
                     16'($urandom_range(0, 65535)), 1'b0);
      for (int i = 0; i < 6; i++) begin
        send_command(CmdWrMem, base + 16'(i), 4'($urandom_range(0, 15)),
                     rand_insn(), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          send_command(CmdBreak, base + 16'($urandom_range(0, 7)), 4'd0, 16'h0,
                       1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) // trap back into privilege now and then
        send_command(CmdWrMem, base, 4'd0, {OpTrap, 4'h0, 8'($urandom_range(0, 255))}, 1'b0);
      for (int i = 0; i < 8; i++)
        send_command(CmdStep, 16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)),
                     16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      send_command(CmdRdReg, 16'h0, 4'($urandom_range(0, 15)), 16'h0, 1'b0);
      if ($urandom_range(0, 9) == 0)
        send_command(3'($urandom_range(5, 7)), 16'($urandom_range(0, 65535)),
                     4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)), 1'b1);
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("ran %0d commands, %0d results checked: directed corner steps and random",
             sent, results_seen);
    $display("programs with breakpoints, privilege changes and illegal fetches");
    if (errors == 0) begin
      $display("** sixteen_bit_cpu_instruction_step_core: PASSED **");
    end else begin
      $display("** sixteen_bit_cpu_instruction_step_core: FAILED **");
    end
    $finish;
  end

endmodule

### sixteen_bit_cpu_instruction_step_core.f
hw/rtl/sbcpu_pkg.sv
hw/rtl/sbcpu_ram.sv
hw/rtl/sbcpu_div.sv
hw/rtl/sbcpu_dp.sv
hw/rtl/sbcpu_ctrl.sv
hw/rtl/sixteen_bit_cpu_instruction_step_core.sv
tb/sbcpu_step_checker.sv
tb/tb.sv
